### src/pdsu_pkg.sv
// Shared types and codes for the P-code data stack unit.
package pdsu_pkg;

  // Number of words the stack holds; the result field widths are sized for it.
  localparam int STACK_DEPTH = 1024;

  localparam logic [3:0] FN_CLEAR     = 4'd0;
  localparam logic [3:0] FN_ALLOC     = 4'd1;
  localparam logic [3:0] FN_PUSH      = 4'd2;
  localparam logic [3:0] FN_POP       = 4'd3;
  localparam logic [3:0] FN_LOAD      = 4'd4;
  localparam logic [3:0] FN_STORE     = 4'd5;
  localparam logic [3:0] FN_LOAD_ADDR = 4'd6;
  localparam logic [3:0] FN_IND_LOAD  = 4'd7;
  localparam logic [3:0] FN_IND_STORE = 4'd8;
  localparam logic [3:0] FN_BOUNDS    = 4'd9;
  localparam logic [3:0] FN_SET_BASE  = 4'd10;
  localparam logic [3:0] FN_SET_SIZE  = 4'd11;
  localparam logic [3:0] FN_PEEK      = 4'd12;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVER    = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_BOUNDS  = 3'd4;

  typedef struct packed {
    logic [3:0]         func;
    logic [3:0]         level;
    logic signed [11:0] offset;
    logic signed [31:0] value;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic [10:0]        depth_now;
    logic [9:0]         base_now;
  } out_item_t;

  // Operation class worked out by the front end.
  typedef struct packed {
    logic pop_first;
    logic walk;
    logic resize;
    logic level_bad;
  } cls_t;

  typedef struct packed {
    in_item_t item;
    cls_t     cls;
  } q_item_t;

endpackage

### src/pcode_data_stack_unit_core.sv
// Top level of the P-code data stack unit: front queue plus execution engine.
//
//   channel   ports                          direction
//   input     in_valid / in_ready / in_data  operation in
//   result    out_valid / out_ready / out_data  one result per operation out
//
// Load, store and load address follow the static links with one memory read
// per hop, and a resize that grows zeroes each new word in turn. Reset is
// synchronous and active low and leaves an empty stack with base zero; the
// stack memory needs no clearing. The front queue keeps taking up to two
// operations while the result register waits for the consumer.
module pcode_data_stack_unit_core #(
  parameter int MAX_LEVEL   = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdsu_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdsu_pkg::out_item_t  out_data
);
  import pdsu_pkg::*;

  logic    q_valid, q_ready;
  q_item_t q_item;

  pdsu_front #(.MAX_LEVEL(MAX_LEVEL)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  pdsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.depth_now) <= 32'(STACK_DEPTH))
    else $error("depth exceeds stack size");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_BOUNDS)
    else $error("illegal status code");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_value == 32'sd0)
    else $error("faulted result carries data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

### src/pdsu_front.sv
// Front end: classifies incoming operations and queues them for the engine.
module pdsu_front #(
  parameter int MAX_LEVEL = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdsu_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output pdsu_pkg::q_item_t q_item
);
  import pdsu_pkg::*;

  q_item_t    entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  q_item_t    new_item;
  logic       push, pop;

  always_comb begin
    new_item.item = in_data;
    new_item.cls.pop_first = (in_data.func == FN_POP) || (in_data.func == FN_STORE) ||
                             (in_data.func == FN_IND_LOAD) ||
                             (in_data.func == FN_IND_STORE) || (in_data.func == FN_BOUNDS);
    new_item.cls.walk   = (in_data.func == FN_LOAD) || (in_data.func == FN_LOAD_ADDR);
    new_item.cls.resize = (in_data.func == FN_ALLOC) || (in_data.func == FN_SET_SIZE);
    new_item.cls.level_bad = 32'(in_data.level) > 32'(MAX_LEVEL);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### src/pdsu_back.sv
// Back end: stack memory, operation sequencer and result register.
module pdsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  pdsu_pkg::q_item_t  q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pdsu_pkg::out_item_t out_data
);
  import pdsu_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_POPD  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_WALKD = 4'd4;
  localparam logic [3:0] S_ACCD  = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [31:0] cell_mem [STACK_DEPTH];
  logic [31:0] rdata_r;
  logic        mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [31:0] mem_wd;

  logic [3:0]  state_r, state_nxt;
  q_item_t     op_r, op_nxt;
  logic [CW-1:0] tc_r, tc_nxt, tgt_r, tgt_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic signed [33:0] cur_r, cur_nxt;
  logic [3:0]  hops_r, hops_nxt;
  logic [31:0] w_r, w_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] res_r, res_nxt;
  logic        second_r, second_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic signed [33:0] tc_s, n_s, sum_s, rd_s, val_s, lo_s, hi_s;
  logic [CW-1:0] tc_m1;

  function automatic logic in_stk(input logic signed [33:0] x,
                                  input logic signed [33:0] top);
    in_stk = (x >= 34'sd0) && (x < top);
  endfunction

  always_comb begin
    tc_s  = $signed(34'(tc_r));
    tc_m1 = tc_r - CW'(1);
    val_s = 34'(op_r.item.value);
    lo_s  = 34'(op_r.item.bound_low);
    hi_s  = 34'(op_r.item.bound_high);
    rd_s  = 34'($signed(rdata_r));
    sum_s = cur_r + 34'(op_r.item.offset);
    n_s   = (op_r.item.func == FN_ALLOC) ? ($signed(34'(fb_r)) + val_s) : val_s;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tc_nxt     = tc_r;
    tgt_nxt    = tgt_r;
    fb_nxt     = fb_r;
    cur_nxt    = cur_r;
    hops_nxt   = hops_r;
    w_nxt      = w_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    second_nxt = second_r;
    q_ready    = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = tc_m1[AW-1:0];
    mem_we     = 1'b0;
    mem_wa     = tc_r[AW-1:0];
    mem_wd     = 32'd0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready    = 1'b1;
          op_nxt     = q_item;
          st_nxt     = ST_OK;
          res_nxt    = 32'd0;
          second_nxt = 1'b0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        if (op_r.cls.pop_first) begin
          if (tc_r == '0) begin
            st_nxt = ST_UNDER;
          end else begin
            tc_nxt    = tc_m1;
            mem_re    = 1'b1;
            state_nxt = S_POPD;
          end
        end else if (op_r.cls.walk) begin
          if (op_r.cls.level_bad) begin
            st_nxt = ST_BADADDR;
          end else begin
            cur_nxt   = $signed(34'(fb_r));
            hops_nxt  = op_r.item.level;
            state_nxt = S_WALK;
          end
        end else if (op_r.cls.resize) begin
          if (n_s > DEPTH_S) begin
            st_nxt = ST_OVER;
          end else if (n_s < 34'sd0) begin
            st_nxt = ST_UNDER;
          end else if (n_s > tc_s) begin
            tgt_nxt   = n_s[CW-1:0];
            state_nxt = S_FILL;
          end else begin
            tc_nxt = n_s[CW-1:0];
          end
        end else begin
          priority case (op_r.item.func)
            FN_CLEAR: begin
              tc_nxt = '0;
              fb_nxt = '0;
            end
            FN_PUSH: begin
              if (tc_r == DEPTH_C) begin
                st_nxt = ST_OVER;
              end else begin
                mem_we = 1'b1;
                mem_wd = op_r.item.value;
                tc_nxt = tc_r + CW'(1);
              end
            end
            FN_SET_BASE: begin
              if (val_s < 34'sd0 || val_s >= DEPTH_S) st_nxt = ST_BADADDR;
              else fb_nxt = val_s[AW-1:0];
            end
            FN_PEEK: begin
              if (!in_stk(val_s, tc_s)) begin
                st_nxt = ST_BADADDR;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = val_s[AW-1:0];
                state_nxt = S_ACCD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POPD: begin
        state_nxt = S_FIN;
        priority case (op_r.item.func)
          FN_POP: res_nxt = rdata_r;
          FN_STORE: begin
            w_nxt = rdata_r;
            if (op_r.cls.level_bad) begin
              st_nxt = ST_BADADDR;
            end else begin
              cur_nxt   = $signed(34'(fb_r));
              hops_nxt  = op_r.item.level;
              state_nxt = S_WALK;
            end
          end
          FN_IND_LOAD: begin
            if (!in_stk(rd_s, tc_s)) begin
              st_nxt = ST_BADADDR;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = rd_s[AW-1:0];
              state_nxt = S_ACCD;
            end
          end
          FN_IND_STORE: begin
            if (!second_r) begin
              // First pop gave the data word; now pop the address.
              w_nxt = rdata_r;
              if (tc_r == '0) begin
                st_nxt = ST_UNDER;
              end else begin
                tc_nxt     = tc_m1;
                mem_re     = 1'b1;
                second_nxt = 1'b1;
                state_nxt  = S_POPD;
              end
            end else if (!in_stk(rd_s, tc_s)) begin
              st_nxt = ST_BADADDR;
            end else begin
              mem_we = 1'b1;
              mem_wa = rd_s[AW-1:0];
              mem_wd = w_r;
            end
          end
          default: begin
            // Bounds check: the popped index goes back on when it is legal.
            if (rd_s < lo_s || rd_s > hi_s) st_nxt = ST_BOUNDS;
            else tc_nxt = tc_r + CW'(1);
          end
        endcase
      end
      S_WALK: begin
        if (hops_r == 4'd0) begin
          state_nxt = S_FIN;
          if (!in_stk(sum_s, tc_s)) begin
            st_nxt = ST_BADADDR;
          end else if (op_r.item.func == FN_LOAD) begin
            mem_re    = 1'b1;
            mem_ra    = sum_s[AW-1:0];
            state_nxt = S_ACCD;
          end else if (op_r.item.func == FN_STORE) begin
            mem_we = 1'b1;
            mem_wa = sum_s[AW-1:0];
            mem_wd = w_r;
          end else if (tc_r == DEPTH_C) begin
            st_nxt = ST_OVER;
          end else begin
            mem_we = 1'b1;
            mem_wd = sum_s[31:0];
            tc_nxt = tc_r + CW'(1);
          end
        end else if (!in_stk(cur_r, tc_s)) begin
          st_nxt    = ST_BADADDR;
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = cur_r[AW-1:0];
          state_nxt = S_WALKD;
        end
      end
      S_WALKD: begin
        cur_nxt   = rd_s;
        hops_nxt  = hops_r - 4'd1;
        state_nxt = S_WALK;
      end
      S_ACCD: begin
        state_nxt = S_FIN;
        if (op_r.item.func == FN_PEEK) begin
          res_nxt = rdata_r;
        end else if (tc_r == DEPTH_C) begin
          st_nxt = ST_OVER;
        end else begin
          mem_we = 1'b1;
          mem_wd = rdata_r;
          tc_nxt = tc_r + CW'(1);
        end
      end
      S_FILL: begin
        if (tc_r == tgt_r) begin
          state_nxt = S_FIN;
        end else begin
          mem_we = 1'b1;
          tc_nxt = tc_r + CW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = res_r;
          out_data_nxt.status       = st_r;
          out_data_nxt.depth_now    = 11'(tc_r);
          out_data_nxt.base_now     = 10'(fb_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= '0;
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tgt_r      <= tgt_nxt;
    cur_r      <= cur_nxt;
    hops_r     <= hops_nxt;
    w_r        <= w_nxt;
    st_r       <= st_nxt;
    res_r      <= res_nxt;
    second_r   <= second_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= cell_mem[mem_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
